[hw/rtl/upd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder package
// Shared widths, limits and the queue entry type used between the front end,
// the queue and the back end.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam int LIMIT_W = 17;
    localparam int NUM_SLOTS = 6;
    localparam int SLOT_W = 3;
    localparam logic [LIMIT_W-1:0] MAX_STRING_BYTES = 17'h10000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

    typedef struct packed {
        logic [NUM_SLOTS-1:0][7:0] bytes;
        logic [SLOT_W-1:0]         count;
        logic                      term;
    } entry_t;

endpackage

[hw/rtl/url_percent_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder
// Streaming decoder for percent escapes, plus signs and the "&amp;" entity,
// with an output limit on literally copied bytes and a closing terminator.
//
// Channel  Direction  Handshake                  Payload
// in       input      in_valid / in_ready        in_byte, end_of_string
// out      output     out_valid / out_ready      out_byte, last_result
// cfg      input      cfg_wr_en                  cfg_wr_data (output limit)
//
// The front end takes one input transfer per cycle while the queue has room.
// One input byte yields zero to six result bytes, and the back end sends one
// result per cycle while out_ready is high.
// With the queue empty, the first result of an item passes through the queue
// entry and then the output register before it is offered on the output.
// Reset clears the match state, the count, the queue and the output busy flag.
// ----------------------------------------------------------------------------
module url_percent_decoder #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [upd_pkg::LIMIT_W-1:0]  cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   in_byte,
    input  logic                         end_of_string,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   out_byte,
    output logic                         last_result
);
    import upd_pkg::*;

    entry_t push_data;
    entry_t head;
    logic   push;
    logic   full;
    logic   pop;
    logic   empty;

    upd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .push          (push),
        .push_data     (push_data),
        .full          (full)
    );

    upd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    upd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_result (last_result)
    );

endmodule

[hw/rtl/upd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder front end
// Accepts one encoded byte per transfer, runs the match state, applies the
// output limit and writes the resulting bytes of the item as one queue entry.
// ----------------------------------------------------------------------------
module upd_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [upd_pkg::LIMIT_W-1:0]  cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   in_byte,
    input  logic                         end_of_string,
    output logic                         push,
    output upd_pkg::entry_t              push_data,
    input  logic                         full
);
    import upd_pkg::*;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_PCT     = 3'd1;
    localparam logic [2:0] PH_HEX     = 3'd2;
    localparam logic [2:0] PH_AMP     = 3'd3;
    localparam logic [2:0] PH_AMP_A   = 3'd4;
    localparam logic [2:0] PH_AMP_AM  = 3'd5;
    localparam logic [2:0] PH_AMP_AMP = 3'd6;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [LIMIT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } seq_t;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
              || (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        hex_val = (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
    endfunction

    function automatic seq_t held_seq(input logic [2:0] ph, input logic [7:0] h);
        seq_t s;
        s.b = {CH_P, CH_M, CH_A, CH_AMP};
        s.n = 3'd0;
        case (ph)
            PH_PCT:
            begin
                s.b[0] = CH_PCT;
                s.n = 3'd1;
            end
            PH_HEX:
            begin
                s.b[0] = CH_PCT;
                s.b[1] = h;
                s.n = 3'd2;
            end
            PH_AMP:     s.n = 3'd1;
            PH_AMP_A:   s.n = 3'd2;
            PH_AMP_AM:  s.n = 3'd3;
            PH_AMP_AMP: s.n = 3'd4;
            default:    s.n = 3'd0;
        endcase
        return s;
    endfunction

    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [2:0]         phase_reg, phase_next;
    logic               stopped_reg, stopped_next;
    logic [LIMIT_W-1:0] count_reg, count_next;
    logic [7:0]         held_reg, held_next;

    logic                        accept;
    logic                        fail;
    logic                        do_idle;
    logic [2:0]                  p1;
    logic [7:0]                  h1;
    logic                        b_valid;
    logic                        b_lit;
    logic [7:0]                  b_byte;
    seq_t                        seq_a;
    seq_t                        seq_c;
    logic [NUM_SLOTS-1:0][7:0]   cand_b;
    logic [NUM_SLOTS-1:0]        cand_lit;
    logic [SLOT_W-1:0]           n_cand;
    logic [SLOT_W-1:0]           pos;
    logic [SLOT_W-1:0]           cidx;
    logic [LIMIT_W-1:0]          lim_eff;
    logic [LIMIT_W:0]            diff;
    logic [SLOT_W-1:0]           dsat;
    logic                        stop_now;
    logic [SLOT_W-1:0]           m;
    logic [LIMIT_W:0]            sum;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        fail    = 1'b0;
        do_idle = 1'b0;
        p1      = phase_reg;
        b_valid = 1'b0;
        b_lit   = 1'b0;
        b_byte  = in_byte;

        if (stopped_reg)
        begin
            p1 = PH_IDLE;
        end
        else
        begin
            case (phase_reg)
                PH_PCT:
                begin
                    if (is_hex(in_byte)) p1 = PH_HEX;
                    else fail = 1'b1;
                end
                PH_HEX:
                begin
                    if (is_hex(in_byte))
                    begin
                        b_valid = 1'b1;
                        b_byte  = {hex_val(held_reg), hex_val(in_byte)};
                        p1      = PH_IDLE;
                    end
                    else fail = 1'b1;
                end
                PH_AMP:
                begin
                    if (in_byte == CH_A) p1 = PH_AMP_A;
                    else fail = 1'b1;
                end
                PH_AMP_A:
                begin
                    if (in_byte == CH_M) p1 = PH_AMP_AM;
                    else fail = 1'b1;
                end
                PH_AMP_AM:
                begin
                    if (in_byte == CH_P) p1 = PH_AMP_AMP;
                    else fail = 1'b1;
                end
                PH_AMP_AMP:
                begin
                    if (in_byte == CH_SEMI)
                    begin
                        b_valid = 1'b1;
                        b_byte  = CH_AMP;
                        p1      = PH_IDLE;
                    end
                    else fail = 1'b1;
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase

            if (fail) do_idle = 1'b1;

            if (do_idle)
            begin
                p1 = PH_IDLE;
                if (in_byte == CH_PCT) p1 = PH_PCT;
                else if (in_byte == CH_AMP) p1 = PH_AMP;
                else if (in_byte == CH_PLUS)
                begin
                    b_valid = 1'b1;
                    b_byte  = CH_SPACE;
                end
                else
                begin
                    b_valid = 1'b1;
                    b_lit   = 1'b1;
                    b_byte  = in_byte;
                end
            end
        end

        h1 = (p1 == PH_HEX && phase_reg == PH_PCT && !stopped_reg) ? in_byte : held_reg;

        seq_a = held_seq(phase_reg, held_reg);
        if (!fail) seq_a.n = 3'd0;
        seq_c = held_seq(p1, h1);
        if (!end_of_string) seq_c.n = 3'd0;

        n_cand = seq_a.n + {2'b00, b_valid} + seq_c.n;

        pos  = '0;
        cidx = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            pos  = SLOT_W'(i);
            cidx = pos - seq_a.n - {2'b00, b_valid};
            if (pos < seq_a.n)
            begin
                cand_b[i]   = seq_a.b[pos[1:0]];
                cand_lit[i] = 1'b1;
            end
            else if (pos == seq_a.n && b_valid)
            begin
                cand_b[i]   = b_byte;
                cand_lit[i] = b_lit;
            end
            else
            begin
                cand_b[i]   = seq_c.b[cidx[1:0]];
                cand_lit[i] = 1'b1;
            end
        end

        lim_eff = (limit_reg > MAX_STRING_BYTES) ? MAX_STRING_BYTES : limit_reg;
        diff    = {1'b0, lim_eff} - {1'b0, count_reg};
        if (diff[LIMIT_W] || diff == '0) dsat = 3'd0;
        else if (diff[LIMIT_W-1:SLOT_W] != '0) dsat = 3'd7;
        else dsat = diff[SLOT_W-1:0];

        stop_now = 1'b0;
        m        = n_cand;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (SLOT_W'(i) < n_cand && cand_lit[i] && SLOT_W'(i + 1) >= dsat)
            begin
                stop_now = 1'b1;
                m        = SLOT_W'(i + 1);
            end
        end

        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            push_data.bytes[i] = (end_of_string && SLOT_W'(i) == m) ? 8'h00 : cand_b[i];
        end
        push_data.count = m + {2'b00, end_of_string};
        push_data.term  = end_of_string;

        sum = {1'b0, count_reg} + (LIMIT_W + 1)'(m);

        limit_next   = cfg_wr_en ? cfg_wr_data : limit_reg;
        phase_next   = phase_reg;
        stopped_next = stopped_reg;
        count_next   = count_reg;
        held_next    = held_reg;
        if (accept)
        begin
            held_next = h1;
            if (end_of_string)
            begin
                phase_next   = PH_IDLE;
                stopped_next = 1'b0;
                count_next   = '0;
            end
            else
            begin
                phase_next   = (stopped_reg || stop_now) ? PH_IDLE : p1;
                stopped_next = stopped_reg || stop_now;
                count_next   = sum[LIMIT_W] ? COUNT_MAX : sum[LIMIT_W-1:0];
            end
        end
    end

    assign push = accept && (push_data.count != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIMIT_RESET;
            phase_reg   <= PH_IDLE;
            stopped_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            limit_reg   <= limit_next;
            phase_reg   <= phase_next;
            stopped_reg <= stopped_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

[hw/rtl/upd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder entry queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module upd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  upd_pkg::entry_t push_data,
    output logic            full,
    input  logic            pop,
    output upd_pkg::entry_t head,
    output logic            empty
);
    import upd_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCount = CntW'(DEPTH);

    entry_t          mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full  = (count_reg == FullCount);
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastIdx) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastIdx) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[hw/rtl/upd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder back end
// Loads one queue entry into an output register and sends its bytes one
// transfer at a time, marking the terminator.
// ----------------------------------------------------------------------------
module upd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  upd_pkg::entry_t head,
    input  logic            empty,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            last_result
);
    import upd_pkg::*;

    entry_t            entry_reg, entry_next;
    logic              busy_reg, busy_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              final_byte;
    logic              done;

    assign out_valid   = busy_reg;
    assign out_byte    = entry_reg.bytes[idx_reg];
    assign final_byte  = (idx_reg == entry_reg.count - 1'b1);
    assign last_result = entry_reg.term && final_byte;
    assign done        = busy_reg && out_ready && final_byte;
    assign pop         = !empty && (!busy_reg || done);

    always_comb
    begin
        entry_next = entry_reg;
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        if (pop)
        begin
            entry_next = head;
            busy_next  = 1'b1;
            idx_next   = '0;
        end
        else if (done)
        begin
            busy_next = 1'b0;
            idx_next  = '0;
        end
        else if (busy_reg && out_ready)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

[hw/rtl/upd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder checker
// Port-level assertions on the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module upd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_result
);

    // A stalled result holds its value until it is transferred.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_result))
        else $error("output changed during a stall");

    // The terminator always carries a zero byte.
    a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_result |-> out_byte == 8'h00)
        else $error("terminator byte is not zero");

    // Nothing is offered on the output right after reset.
    a_reset_out: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

    // The queue is empty after reset, so the input is open.
    a_reset_in: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> in_ready)
        else $error("input not ready right after reset");

    // Once a result is offered it stays offered until transferred.
    a_out_keep: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("output valid dropped without a transfer");

endmodule

bind url_percent_decoder upd_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_result (last_result)
);
